/* src/bfba_pkg.sv */
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared constants, codes and helpers for the bitmap/FAT block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 4096;

    localparam int CFG_W = 13;
    localparam int BLK_W = 12;
    localparam int REQ_W = 3;
    localparam int ST_W  = 2;

    localparam logic [CFG_W-1:0] NUM_BLOCKS_RESET = 13'd4096;
    localparam int MIN_BLOCKS = 4;

    // bitmap memory word
    localparam int WORD_SHIFT = 5;
    localparam int WORD_W     = 1 << WORD_SHIFT;

    localparam logic [REQ_W-1:0] REQ_FORMAT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FOLLOW = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    // {found, position} of the lowest clear bit
    function automatic logic [WORD_SHIFT:0] first_zero(input logic [WORD_W-1:0] w);
        logic [WORD_SHIFT-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = WORD_SHIFT'(i);
            end
        end
        return {~(&w), pos};
    endfunction

endpackage

/* src/bfba_ram.sv */
// ----------------------------------------------------------------------------
// bfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/bitmap_fat_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_fat_block_allocator
// Block allocator with a free bitmap and a chained allocation table.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; one result beat
// follows, shown for one cycle with done high. The receiver cannot stall.
// cfg_data (num_blocks) is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high.
// Path from accept to done, by request:
//   range error, unknown type ........ done is registered from idle
//   read link, free, follow w/ link .. via S_LINK or S_FREE
//   allocate new ..................... via S_SCAN
//   follow, extending the chain ...... via S_LINK, then S_SCAN
//   format ........................... via the S_CLEAR sweep
// S_SCAN reads bitmap words from index 0 up to the 32-bit word that holds the
// first free block, at most ceil(n/32) - 1. The scan reads one bitmap word per
// cycle from the bitmap RAM; format sweeps the link RAM one entry per cycle.
// After reset the same sweep runs over all MAX_BLOCKS entries with busy high,
// and produces no result. One request is in flight at a time.
// ----------------------------------------------------------------------------
module bitmap_fat_block_allocator #(
    parameter int MAX_BLOCKS = bfba_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bfba_pkg::REQ_W-1:0]  req_type,
    input  logic [bfba_pkg::BLK_W-1:0]  block_in,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bfba_pkg::CFG_W-1:0]  cfg_data,
    output logic                        done,
    output logic [bfba_pkg::BLK_W-1:0]  block_out,
    output logic                        allocated,
    output logic                        is_end,
    output logic [bfba_pkg::ST_W-1:0]   status
);

    localparam int BIDX_W = $clog2(MAX_BLOCKS);
    localparam int N_W    = $clog2(MAX_BLOCKS + 1);
    localparam int LINK_W = BIDX_W + 1;
    localparam int WORDS  = (MAX_BLOCKS + bfba_pkg::WORD_W - 1) / bfba_pkg::WORD_W;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RST_N  = (int'(bfba_pkg::NUM_BLOCKS_RESET) > MAX_BLOCKS) ?
                            MAX_BLOCKS : int'(bfba_pkg::NUM_BLOCKS_RESET);
    localparam logic [LINK_W-1:0] LINK_END = {LINK_W{1'b1}};
    localparam int WS = bfba_pkg::WORD_SHIFT;
    localparam int WW = bfba_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_FREE,
        S_SCAN
    } state_t;

    state_t                       state_reg;
    logic [bfba_pkg::CFG_W-1:0]   num_blocks_reg;
    logic [bfba_pkg::REQ_W-1:0]   req_reg;
    logic [bfba_pkg::BLK_W-1:0]   blk_reg;
    logic [N_W-1:0]               fmt_n_reg;
    logic                         fmt_req_reg;
    logic [BIDX_W-1:0]            clr_reg;
    logic [WAW-1:0]               scan_addr_reg;
    logic                         dv_reg;
    logic [WAW-1:0]               didx_reg;
    logic                         done_reg;
    logic [bfba_pkg::BLK_W-1:0]   block_out_reg;
    logic                         allocated_reg;
    logic                         is_end_reg;
    logic [bfba_pkg::ST_W-1:0]    status_reg;

    logic [N_W-1:0]    n_eff;
    logic [31:0]       n32;
    logic [31:0]       blk32;
    logic              in_range;
    logic [WAW-1:0]    last_idx;
    logic [WS-1:0]     last_bit;
    logic [WW-1:0]     clr_mask;
    logic [WW-1:0]     scan_word;
    logic [WS:0]       fz;
    logic [31:0]       found_blk;

    logic              bm_we;
    logic [WAW-1:0]    bm_waddr;
    logic [WW-1:0]     bm_wdata;
    logic [WAW-1:0]    bm_raddr;
    logic [WW-1:0]     bm_rdata;
    logic              ln_we;
    logic [BIDX_W-1:0] ln_waddr;
    logic [LINK_W-1:0] ln_wdata;
    logic [BIDX_W-1:0] ln_raddr;
    logic [LINK_W-1:0] ln_rdata;

    bfba_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bfba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_links (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign block_out = block_out_reg;
    assign allocated = allocated_reg;
    assign is_end    = is_end_reg;
    assign status    = status_reg;

    always_comb
    begin
        logic [31:0] nb;
        nb = 32'(num_blocks_reg);
        priority if (nb < 32'(bfba_pkg::MIN_BLOCKS))
        begin
            n32 = 32'(bfba_pkg::MIN_BLOCKS);
        end
        else if (nb > 32'(MAX_BLOCKS))
        begin
            n32 = 32'(MAX_BLOCKS);
        end
        else
        begin
            n32 = nb;
        end
        n_eff    = N_W'(n32);
        blk32    = 32'(block_in);
        in_range = (blk32 < 32'(n_eff));
        last_idx = WAW'((32'(n_eff) - 32'd1) >> WS);
        last_bit = WS'(32'(n_eff) - 32'd1);
    end

    // reserved bits of the bitmap word being cleared
    always_comb
    begin
        logic [31:0] na;
        logic [31:0] nz;
        na = 32'(fmt_n_reg) - 32'd2;
        nz = 32'(fmt_n_reg) - 32'd1;
        clr_mask = '0;
        if (clr_reg == '0)
        begin
            clr_mask[1:0] = 2'b11;
        end
        if ((na >> WS) == 32'(clr_reg))
        begin
            clr_mask[na[WS-1:0]] = 1'b1;
        end
        if ((nz >> WS) == 32'(clr_reg))
        begin
            clr_mask[nz[WS-1:0]] = 1'b1;
        end
    end

    // blocks below 2 and at or above n count as used
    always_comb
    begin
        scan_word = bm_rdata;
        if (didx_reg == '0)
        begin
            scan_word[1:0] = 2'b11;
        end
        if (didx_reg == last_idx)
        begin
            for (int j = 0; j < WW; j++)
            begin
                if (WS'(j) > last_bit)
                begin
                    scan_word[j] = 1'b1;
                end
            end
        end
        fz        = bfba_pkg::first_zero(scan_word);
        found_blk = (32'(didx_reg) << WS) | 32'(fz[WS-1:0]);
    end

    always_comb
    begin
        bm_we    = 1'b0;
        bm_waddr = didx_reg;
        bm_wdata = bm_rdata | (WW'(1) << fz[WS-1:0]);
        bm_raddr = (state_reg == S_SCAN) ? scan_addr_reg : WAW'(blk32 >> WS);
        ln_we    = 1'b0;
        ln_waddr = BIDX_W'(blk_reg);
        ln_wdata = LINK_W'(found_blk);
        ln_raddr = BIDX_W'(block_in);
        unique case (state_reg)
            S_CLEAR:
            begin
                ln_we    = 1'b1;
                ln_waddr = clr_reg;
                ln_wdata = LINK_END;
                bm_we    = (32'(clr_reg) < 32'(WORDS));
                bm_waddr = WAW'(clr_reg);
                bm_wdata = clr_mask;
            end
            S_FREE:
            begin
                bm_we    = 1'b1;
                bm_waddr = WAW'(32'(blk_reg) >> WS);
                bm_wdata = bm_rdata & ~(WW'(1) << blk_reg[WS-1:0]);
            end
            S_SCAN:
            begin
                if (dv_reg && fz[WS])
                begin
                    bm_we = 1'b1;
                    ln_we = (req_reg == bfba_pkg::REQ_FOLLOW);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            num_blocks_reg <= bfba_pkg::NUM_BLOCKS_RESET;
            req_reg        <= '0;
            blk_reg        <= '0;
            fmt_n_reg      <= N_W'(RST_N);
            fmt_req_reg    <= 1'b0;
            clr_reg        <= '0;
            scan_addr_reg  <= '0;
            dv_reg         <= 1'b0;
            didx_reg       <= '0;
            done_reg       <= 1'b0;
            block_out_reg  <= '0;
            allocated_reg  <= 1'b0;
            is_end_reg     <= 1'b0;
            status_reg     <= bfba_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                num_blocks_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BIDX_W'(1);
                    if (32'(clr_reg) == 32'(MAX_BLOCKS - 1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= S_IDLE;
                        if (fmt_req_reg)
                        begin
                            done_reg      <= 1'b1;
                            block_out_reg <= '0;
                            allocated_reg <= 1'b0;
                            is_end_reg    <= 1'b0;
                            status_reg    <= bfba_pkg::ST_OK;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg       <= req_type;
                        blk_reg       <= block_in;
                        scan_addr_reg <= '0;
                        dv_reg        <= 1'b0;
                        block_out_reg <= '0;
                        allocated_reg <= 1'b0;
                        is_end_reg    <= 1'b0;
                        status_reg    <= bfba_pkg::ST_OK;
                        unique case (req_type)
                            bfba_pkg::REQ_FORMAT:
                            begin
                                fmt_n_reg   <= n_eff;
                                fmt_req_reg <= 1'b1;
                                clr_reg     <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            bfba_pkg::REQ_FOLLOW, bfba_pkg::REQ_READ:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= S_LINK;
                                end
                                else
                                begin
                                    status_reg <= bfba_pkg::ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                            end
                            bfba_pkg::REQ_FREE:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= S_FREE;
                                end
                                else
                                begin
                                    status_reg <= bfba_pkg::ST_RANGE;
                                    done_reg   <= 1'b1;
                                end
                            end
                            bfba_pkg::REQ_ALLOC:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_LINK:
                begin
                    priority if (ln_rdata != LINK_END)
                    begin
                        block_out_reg <= bfba_pkg::BLK_W'(ln_rdata);
                        done_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (req_reg == bfba_pkg::REQ_READ)
                    begin
                        is_end_reg <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_FREE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    dv_reg   <= 1'b1;
                    didx_reg <= scan_addr_reg;
                    if (scan_addr_reg != last_idx)
                    begin
                        scan_addr_reg <= scan_addr_reg + WAW'(1);
                    end
                    if (dv_reg)
                    begin
                        priority if (fz[WS])
                        begin
                            block_out_reg <= bfba_pkg::BLK_W'(found_blk);
                            allocated_reg <= 1'b1;
                            done_reg      <= 1'b1;
                            dv_reg        <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else if (didx_reg == last_idx)
                        begin
                            status_reg <= bfba_pkg::ST_NO_FREE;
                            done_reg   <= 1'b1;
                            dv_reg     <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
